FILE: hw/rtl/tsmq_pkg.sv
// Shared types and constants for the thread scheduler with mutex wait queues.
// Used by tsmq_ctrl, tsmq_datapath and thread_scheduler_mutex_queues.
`timescale 1ns / 1ps

package tsmq_pkg;

  // Default pool size and mutex count
  localparam int TSMQ_THREAD_COUNT = 4;
  localparam int TSMQ_MUTEX_COUNT  = 4;

  // Fixed field widths
  localparam int TSMQ_ACT_W  = 3;
  localparam int TSMQ_WORD_W = 16;

  // Scheduling events
  typedef enum logic [TSMQ_ACT_W-1:0] {
    ACT_SPAWN  = 3'd0,
    ACT_YIELD  = 3'd1,
    ACT_LOCK   = 3'd2,
    ACT_UNLOCK = 3'd3,
    ACT_EXIT   = 3'd4
  } tsmq_action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_READY_EMPTY = 2'd2,
    ST_MAIN_EXIT   = 2'd3
  } tsmq_status_t;

  // Decoded queue operation, fixed at accept time
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SPAWN,
    OP_YIELD,
    OP_LOCK_TAKE,
    OP_LOCK_BLOCK,
    OP_UNLOCK_PASS,
    OP_UNLOCK_CLEAR,
    OP_EXIT
  } tsmq_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the transaction and issue table reads
    logic commit;   // write back queue state and load the result register
  } tsmq_cmd_t;

endpackage

FILE: hw/rtl/tsmq_ctrl.sv
// Controller for the thread scheduler: accept / execute sequencing and result valid.
// Depends on tsmq_pkg.
`timescale 1ns / 1ps

module tsmq_ctrl import tsmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tsmq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   room;

  // Result register is free, or is being emptied this cycle
  assign room = !out_valid_r || out_ready;

  // Handshake and commands
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd_o.capture = in_valid && in_ready;
    cmd_o.commit  = (state_r == S_EXEC) && room;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_o.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |=> (state_r == S_EXEC))
    else $error("accepted transaction did not move to execute");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still pending");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

FILE: hw/rtl/tsmq_datapath.sv
// Datapath for the thread scheduler: queue pointers, link table, thread stores
// and the result register. Depends on tsmq_pkg.
`timescale 1ns / 1ps

module tsmq_datapath import tsmq_pkg::*; #(
  parameter  int THREAD_COUNT = TSMQ_THREAD_COUNT,
  parameter  int MUTEX_COUNT  = TSMQ_MUTEX_COUNT,
  localparam int ID_W         = $clog2(THREAD_COUNT + 2),
  localparam int MX_W         = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsmq_cmd_t                     cmd_i,
  input  logic [TSMQ_ACT_W-1:0]         in_action,
  input  logic [MX_W-1:0]               in_mutex_id,
  input  logic [TSMQ_WORD_W-1:0]        in_spawn_entry,
  input  logic signed [TSMQ_WORD_W-1:0] in_spawn_arg,
  output logic [ID_W-1:0]               out_running_thread,
  output logic                          out_switched,
  output logic                          out_fresh_start,
  output logic [TSMQ_WORD_W-1:0]        out_run_entry,
  output logic signed [TSMQ_WORD_W-1:0] out_run_arg,
  output logic [1:0]                    out_status
);

  localparam int             NENT    = THREAD_COUNT + 1;
  localparam int             IX_W    = $clog2(NENT);
  localparam logic [ID_W-1:0] NIL     = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] MAIN_ID = ID_W'(THREAD_COUNT);

  // Thread id to table index; ids up to the main thread fit in IX_W bits
  function automatic logic [IX_W-1:0] ix(input logic [ID_W-1:0] id);
    ix = id[IX_W-1:0];
  endfunction

  // Queue state
  logic [ID_W-1:0]        link_r       [NENT];
  logic [ID_W-1:0]        free_head_r, free_head_nxt;
  logic [ID_W-1:0]        free_tail_r, free_tail_nxt;
  logic [ID_W-1:0]        ready_head_r, ready_head_nxt;
  logic [ID_W-1:0]        ready_tail_r, ready_tail_nxt;
  logic [ID_W-1:0]        wait_head_r  [MUTEX_COUNT];
  logic [ID_W-1:0]        wait_tail_r  [MUTEX_COUNT];
  logic [ID_W-1:0]        wait_head_nxt[MUTEX_COUNT];
  logic [ID_W-1:0]        wait_tail_nxt[MUTEX_COUNT];
  logic [MUTEX_COUNT-1:0] locked_r, locked_nxt;
  logic [ID_W-1:0]        cur_r, cur_nxt;
  logic [NENT-1:0]        started_r, started_nxt;

  // Thread stores, undefined until a spawn writes them
  logic [TSMQ_WORD_W-1:0] entry_mem [NENT];
  logic [TSMQ_WORD_W-1:0] arg_mem   [NENT];

  // Decode side
  logic                   m_in_range;
  logic [MX_W-1:0]        m_sel;
  logic                   w_locked;
  logic [ID_W-1:0]        w_head, w_tail;
  logic                   ready_empty;
  tsmq_op_t               op_d;
  tsmq_status_t           st_d;
  logic [ID_W-1:0]        next_d;
  logic [ID_W-1:0]        lk_ptr;
  logic [IX_W-1:0]        lk_raddr;

  // Transaction registers
  tsmq_op_t               op_r;
  tsmq_status_t           st_r;
  logic [ID_W-1:0]        next_r;
  logic [MX_W-1:0]        m_r;
  logic [ID_W-1:0]        wh_r, wt_r;
  logic [TSMQ_WORD_W-1:0] sp_entry_r, sp_arg_r;
  logic                   started_q_r;
  logic [ID_W-1:0]        link_q_r;
  logic [TSMQ_WORD_W-1:0] ent_q_r, arg_q_r;

  // Write-back side
  logic                   lk_we;
  logic [IX_W-1:0]        lk_waddr;
  logic [ID_W-1:0]        lk_wdata;
  logic                   ready_single;
  logic                   sw;
  logic                   fresh;

  // Output register
  logic [ID_W-1:0]        run_thread_r;
  logic                   switched_r, fresh_r;
  logic [TSMQ_WORD_W-1:0] run_entry_r, run_arg_r;
  logic [1:0]             status_r;

  // Mutex selection for the incoming transaction
  always_comb begin
    m_in_range  = (MX_W + 1)'(in_mutex_id) < (MX_W + 1)'(MUTEX_COUNT);
    m_sel       = m_in_range ? in_mutex_id : '0;
    w_locked    = locked_r[m_sel];
    w_head      = wait_head_r[m_sel];
    w_tail      = wait_tail_r[m_sel];
    ready_empty = (ready_head_r == NIL);
  end

  // Decode: pick the operation, the next thread and the queue head to pop
  always_comb begin
    op_d   = OP_NONE;
    st_d   = ST_OK;
    next_d = cur_r;
    lk_ptr = ready_head_r;
    case (in_action)
      ACT_SPAWN: begin
        lk_ptr = free_head_r;
        if (free_head_r == NIL) begin
          st_d = ST_NO_FREE;
        end else begin
          op_d = OP_SPAWN;
        end
      end
      ACT_YIELD: begin
        if (!ready_empty) begin
          op_d   = OP_YIELD;
          next_d = ready_head_r;
        end
      end
      ACT_LOCK: begin
        if (m_in_range) begin
          if (!w_locked) begin
            op_d = OP_LOCK_TAKE;
          end else if (ready_empty) begin
            st_d = ST_READY_EMPTY;
          end else begin
            op_d   = OP_LOCK_BLOCK;
            next_d = ready_head_r;
          end
        end
      end
      ACT_UNLOCK: begin
        lk_ptr = w_head;
        if (m_in_range) begin
          if (w_head != NIL) begin
            op_d   = OP_UNLOCK_PASS;
            next_d = w_head;
          end else begin
            op_d = OP_UNLOCK_CLEAR;
          end
        end
      end
      ACT_EXIT: begin
        if (cur_r == MAIN_ID) begin
          st_d = ST_MAIN_EXIT;
        end else if (ready_empty) begin
          st_d = ST_READY_EMPTY;
        end else begin
          op_d   = OP_EXIT;
          next_d = ready_head_r;
        end
      end
      default: ;
    endcase
    lk_raddr = (lk_ptr == NIL) ? '0 : ix(lk_ptr);
  end

  // Latch the transaction and its table reads
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r        <= op_d;
      st_r        <= st_d;
      next_r      <= next_d;
      m_r         <= m_sel;
      wh_r        <= w_head;
      wt_r        <= w_tail;
      sp_entry_r  <= in_spawn_entry;
      sp_arg_r    <= in_spawn_arg;
      started_q_r <= started_r[ix(next_d)];
      link_q_r    <= link_r[lk_raddr];
    end
  end

  // Thread stores: written on spawn, read for the thread that runs next
  always_ff @(posedge clk) begin
    if (cmd_i.commit && (op_r == OP_SPAWN)) begin
      entry_mem[ix(free_head_r)] <= sp_entry_r;
      arg_mem[ix(free_head_r)]   <= sp_arg_r;
    end
    if (cmd_i.capture) begin
      ent_q_r <= entry_mem[ix(next_d)];
      arg_q_r <= arg_mem[ix(next_d)];
    end
  end

  // Queue updates; one link write at most, the pop uses the latched link
  always_comb begin
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    wait_head_nxt  = wait_head_r;
    wait_tail_nxt  = wait_tail_r;
    locked_nxt     = locked_r;
    started_nxt    = started_r;
    cur_nxt        = cur_r;
    lk_we          = 1'b0;
    lk_waddr       = ix(ready_tail_r);
    lk_wdata       = cur_r;
    ready_single   = (ready_head_r == ready_tail_r);
    sw             = 1'b0;
    case (op_r)
      OP_SPAWN: begin
        // pop free list, push onto ready tail
        if (free_head_r == free_tail_r) begin
          free_head_nxt = NIL;
          free_tail_nxt = NIL;
        end else begin
          free_head_nxt = link_q_r;
        end
        if (ready_head_r == NIL) begin
          ready_head_nxt = free_head_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = ix(ready_tail_r);
          lk_wdata = free_head_r;
        end
        ready_tail_nxt                = free_head_r;
        started_nxt[ix(free_head_r)] = 1'b0;
      end
      OP_YIELD: begin
        // rotate: current to tail, head out
        lk_we          = 1'b1;
        lk_waddr       = ix(ready_tail_r);
        lk_wdata       = cur_r;
        ready_head_nxt = ready_single ? cur_r : link_q_r;
        ready_tail_nxt = cur_r;
        sw             = 1'b1;
      end
      OP_LOCK_TAKE: begin
        locked_nxt[m_r] = 1'b1;
      end
      OP_LOCK_BLOCK: begin
        if (wh_r == NIL) begin
          wait_head_nxt[m_r] = cur_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = ix(wt_r);
          lk_wdata = cur_r;
        end
        wait_tail_nxt[m_r] = cur_r;
        if (ready_single) begin
          ready_head_nxt = NIL;
          ready_tail_nxt = NIL;
        end else begin
          ready_head_nxt = link_q_r;
        end
        sw = 1'b1;
      end
      OP_UNLOCK_PASS: begin
        // mutex stays locked and goes to the first waiter
        if (ready_head_r == NIL) begin
          ready_head_nxt = cur_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = ix(ready_tail_r);
          lk_wdata = cur_r;
        end
        ready_tail_nxt = cur_r;
        if (wh_r == wt_r) begin
          wait_head_nxt[m_r] = NIL;
          wait_tail_nxt[m_r] = NIL;
        end else begin
          wait_head_nxt[m_r] = link_q_r;
        end
        sw = 1'b1;
      end
      OP_UNLOCK_CLEAR: begin
        locked_nxt[m_r] = 1'b0;
      end
      OP_EXIT: begin
        if (free_head_r == NIL) begin
          free_head_nxt = cur_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = ix(free_tail_r);
          lk_wdata = cur_r;
        end
        free_tail_nxt = cur_r;
        if (ready_single) begin
          ready_head_nxt = NIL;
          ready_tail_nxt = NIL;
        end else begin
          ready_head_nxt = link_q_r;
        end
        sw = 1'b1;
      end
      default: ;
    endcase
    // switch to the chosen thread, first run marks it started
    fresh = sw && !started_q_r;
    if (sw) begin
      cur_nxt = next_r;
      if (!started_q_r) started_nxt[ix(next_r)] = 1'b1;
    end
  end

  // Queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) begin
        link_r[i] <= (i < THREAD_COUNT - 1) ? ID_W'(i + 1) : NIL;
      end
      free_head_r  <= '0;
      free_tail_r  <= ID_W'(THREAD_COUNT - 1);
      ready_head_r <= NIL;
      ready_tail_r <= NIL;
      for (int j = 0; j < MUTEX_COUNT; j++) begin
        wait_head_r[j] <= NIL;
        wait_tail_r[j] <= NIL;
      end
      locked_r  <= '0;
      cur_r     <= MAIN_ID;
      // only main counts as started
      started_r <= {1'b1, {THREAD_COUNT{1'b0}}};
    end else if (cmd_i.commit) begin
      if (lk_we) link_r[lk_waddr] <= lk_wdata;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      wait_head_r  <= wait_head_nxt;
      wait_tail_r  <= wait_tail_nxt;
      locked_r     <= locked_nxt;
      cur_r        <= cur_nxt;
      started_r    <= started_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      run_thread_r <= cur_nxt;
      switched_r   <= (cur_nxt != cur_r);
      fresh_r      <= fresh;
      run_entry_r  <= (cur_nxt == MAIN_ID) ? '0 : ent_q_r;
      run_arg_r    <= (cur_nxt == MAIN_ID) ? '0 : arg_q_r;
      status_r     <= st_r;
    end
  end

  assign out_running_thread = run_thread_r;
  assign out_switched       = switched_r;
  assign out_fresh_start    = fresh_r;
  assign out_run_entry      = run_entry_r;
  assign out_run_arg        = run_arg_r;
  assign out_status         = status_r;

endmodule

FILE: hw/rtl/thread_scheduler_mutex_queues.sv
// Top level of the round-robin thread scheduler with mutex wait queues.
// Depends on tsmq_pkg, tsmq_ctrl and tsmq_datapath.
//
//   Channel   Handshake              Payload
//   in_       in_valid / in_ready    action, mutex_id, spawn_entry, spawn_arg
//   out_      out_valid / out_ready  running_thread, switched, fresh_start,
//                                    run_entry, run_arg, status
//
// Each transaction runs as accept then execute: the accept edge latches it and
// reads the link table and the entry/argument stores; execute writes back the
// queue pointers and loads the result register, stalling only while that register
// is full, and the pop uses the link latched at accept. A transaction can be
// accepted while the previous result is still held. Reset is synchronous, active
// low, and leaves the block ready at once with main running.
`timescale 1ns / 1ps

module thread_scheduler_mutex_queues import tsmq_pkg::*; #(
  parameter  int THREAD_COUNT = TSMQ_THREAD_COUNT,
  parameter  int MUTEX_COUNT  = TSMQ_MUTEX_COUNT,
  localparam int ID_W         = $clog2(THREAD_COUNT + 2),
  localparam int MX_W         = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [TSMQ_ACT_W-1:0]         in_action,
  input  logic [MX_W-1:0]               in_mutex_id,
  input  logic [TSMQ_WORD_W-1:0]        in_spawn_entry,
  input  logic signed [TSMQ_WORD_W-1:0] in_spawn_arg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ID_W-1:0]               out_running_thread,
  output logic                          out_switched,
  output logic                          out_fresh_start,
  output logic [TSMQ_WORD_W-1:0]        out_run_entry,
  output logic signed [TSMQ_WORD_W-1:0] out_run_arg,
  output logic [1:0]                    out_status
);

  tsmq_cmd_t cmd;

  tsmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd)
  );

  tsmq_datapath #(
    .THREAD_COUNT (THREAD_COUNT),
    .MUTEX_COUNT  (MUTEX_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .in_action          (in_action),
    .in_mutex_id        (in_mutex_id),
    .in_spawn_entry     (in_spawn_entry),
    .in_spawn_arg       (in_spawn_arg),
    .out_running_thread (out_running_thread),
    .out_switched       (out_switched),
    .out_fresh_start    (out_fresh_start),
    .out_run_entry      (out_run_entry),
    .out_run_arg        (out_run_arg),
    .out_status         (out_status)
  );

endmodule
